### design/gate_sensor_qualifier_top_defines.svh
// assertion macros for the gate sensor qualifier
`ifndef GATE_SENSOR_QUALIFIER_TOP_DEFINES_SVH
`define GATE_SENSOR_QUALIFIER_TOP_DEFINES_SVH

// same-cycle implication, checked outside reset
`define GSQ_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked outside reset
`define GSQ_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### design/gsq_pkg.sv
// package of types and constants for the gate sensor qualifier
`timescale 1ns / 1ps
package gsq_pkg;

    localparam int THR_W    = 8;
    localparam int CNT_W    = 9;
    localparam int SPEED_W  = 8;
    localparam int LED_W    = 12;
    localparam int PERIOD_W = 16;
    localparam int WAIT_W   = 20;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 20;
    localparam int STEP_W   = 4;

    localparam logic [THR_W-1:0]    RST_LIMIT_THR  = 8'd20;
    localparam logic [THR_W-1:0]    RST_AIR_THR    = 8'd5;
    localparam logic [THR_W-1:0]    RST_RADAR_THR  = 8'd10;
    localparam logic [THR_W-1:0]    RST_GROUND_THR = 8'd0;
    localparam logic [SPEED_W-1:0]  RST_SPEED_DIV  = 8'd4;
    localparam logic [LED_W-1:0]    RST_LED_PERIOD = 12'd250;
    localparam logic [PERIOD_W-1:0] RST_LONG_PER   = 16'd5000;
    localparam logic [WAIT_W-1:0]   RST_CAR_TMO    = 20'd100000;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_LIMIT_THR  = 3'd0,
        CFG_AIR_THR    = 3'd1,
        CFG_RADAR_THR  = 3'd2,
        CFG_GROUND_THR = 3'd3,
        CFG_SPEED_DIV  = 3'd4,
        CFG_LED_PERIOD = 3'd5,
        CFG_LONG_PER   = 3'd6,
        CFG_CAR_TMO    = 3'd7
    } t_cfg_idx;

    typedef struct packed {
        logic [THR_W-1:0]    limit_threshold;
        logic [THR_W-1:0]    air_threshold;
        logic [THR_W-1:0]    radar_threshold;
        logic [THR_W-1:0]    ground_threshold;
        logic [SPEED_W-1:0]  speed_divide;
        logic [LED_W-1:0]    led_period;
        logic [PERIOD_W-1:0] long_period;
        logic [WAIT_W-1:0]   car_timeout;
    } t_cfg;

    typedef struct packed {
        logic mode;
        logic ver_pin;
        logic hor_pin;
        logic air_pin;
        logic radar_pin;
        logic ground_pin;
        logic car_announce;
    } t_in_item;

    typedef struct packed {
        logic ver_reached;
        logic hor_reached;
        logic move_down;
        logic stop_pulse;
        logic clear_speed_pulse;
        logic speed_tick;
        logic led_tick;
        logic long_tick;
        logic air_detect;
        logic radar_detect;
        logic ground_detect;
        logic car_waiting;
    } t_out_item;

    // handshake between the remainder unit and the qualifier state
    typedef struct packed {
        logic             load;
        logic [LED_W-1:0] value;
    } t_mod_load;

endpackage

### design/gsq_cfg_regs.sv
// configuration register file of the gate sensor qualifier
`timescale 1ns / 1ps
module gsq_cfg_regs import gsq_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_wr,
    input  logic [CFG_IDX_W-1:0]  i_index,
    input  logic [CFG_DATA_W-1:0] i_data,
    output t_cfg                  o_cfg,
    output logic                  o_led_wr
);

    t_cfg r_cfg;
    t_cfg n_cfg;

    always_comb begin
        n_cfg    = r_cfg;
        o_led_wr = 1'b0;
        if (i_wr) begin
            unique case (t_cfg_idx'(i_index))
                CFG_LIMIT_THR:  n_cfg.limit_threshold  = i_data[THR_W-1:0];
                CFG_AIR_THR:    n_cfg.air_threshold    = i_data[THR_W-1:0];
                CFG_RADAR_THR:  n_cfg.radar_threshold  = i_data[THR_W-1:0];
                CFG_GROUND_THR: n_cfg.ground_threshold = i_data[THR_W-1:0];
                CFG_SPEED_DIV:  n_cfg.speed_divide     = i_data[SPEED_W-1:0];
                CFG_LED_PERIOD: begin
                    n_cfg.led_period = i_data[LED_W-1:0];
                    o_led_wr         = 1'b1;
                end
                CFG_LONG_PER:   n_cfg.long_period      = i_data[PERIOD_W-1:0];
                CFG_CAR_TMO:    n_cfg.car_timeout      = i_data[WAIT_W-1:0];
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.limit_threshold  <= RST_LIMIT_THR;
            r_cfg.air_threshold    <= RST_AIR_THR;
            r_cfg.radar_threshold  <= RST_RADAR_THR;
            r_cfg.ground_threshold <= RST_GROUND_THR;
            r_cfg.speed_divide     <= RST_SPEED_DIV;
            r_cfg.led_period       <= RST_LED_PERIOD;
            r_cfg.long_period      <= RST_LONG_PER;
            r_cfg.car_timeout      <= RST_CAR_TMO;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    assign o_cfg = r_cfg;

endmodule

### design/gsq_rem_unit.sv
// bit-serial remainder of the period count by the led period
`timescale 1ns / 1ps
module gsq_rem_unit import gsq_pkg::*; (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_start,
    input  logic [PERIOD_W-1:0] i_dividend,
    input  logic [LED_W-1:0]    i_divisor,
    output logic                o_busy,
    output t_mod_load           o_result
);

    logic                r_busy;
    logic [STEP_W-1:0]   r_step;
    logic [PERIOD_W-1:0] r_dividend;
    logic [LED_W-1:0]    r_divisor;
    logic [LED_W-1:0]    r_rem;
    logic [LED_W:0]      shifted;
    logic [LED_W-1:0]    n_rem;

    // one restoring step per cycle, msb of the dividend first
    always_comb begin
        shifted = {r_rem, r_dividend[r_step]};
        if (shifted >= {1'b0, r_divisor}) begin
            n_rem = LED_W'(shifted - {1'b0, r_divisor});
        end else begin
            n_rem = shifted[LED_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_step <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_step <= '1;
        end else if (r_busy) begin
            r_step <= r_step - 1'b1;
            if (r_step == '0) begin
                r_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_dividend <= i_dividend;
            r_divisor  <= i_divisor;
            r_rem      <= '0;
        end else if (r_busy) begin
            r_rem <= n_rem;
        end
    end

    assign o_busy         = r_busy;
    assign o_result.load  = r_busy && (r_step == '0);
    assign o_result.value = n_rem;

endmodule

### design/gsq_qualify.sv
// debounce, divider and sensor qualification state with its update logic
`timescale 1ns / 1ps
module gsq_qualify import gsq_pkg::*; (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_step,
    input  t_in_item            i_item,
    input  t_cfg                i_cfg,
    input  t_mod_load           i_mod,
    output logic [PERIOD_W-1:0] o_period_count,
    output t_out_item           o_result
);

    localparam logic [CNT_W-1:0] CNT_MAX = '1;

    logic [1:0]          r_limit_prev, n_limit_prev;
    logic [CNT_W-1:0]    r_limit_cnt [2];
    logic [CNT_W-1:0]    n_limit_cnt [2];
    logic [1:0]          r_limit_flag, n_limit_flag;
    logic                r_dir, n_dir;
    logic [SPEED_W-1:0]  r_speed_cnt, n_speed_cnt;
    logic [PERIOD_W-1:0] r_period_cnt, n_period_cnt;
    logic [LED_W-1:0]    r_led_mod, n_led_mod;
    logic [2:0]          r_sens_prev, n_sens_prev;
    logic [CNT_W-1:0]    r_sens_cnt [3];
    logic [CNT_W-1:0]    n_sens_cnt [3];
    logic [2:0]          r_sens_lat, n_sens_lat;
    logic                r_car, n_car;
    logic [WAIT_W-1:0]   r_wait_cnt, n_wait_cnt;

    logic [1:0]          l_pin, l_low, l_hit;
    logic [THR_W-1:0]    l_thr [2];
    logic [CNT_W-1:0]    l_inc [2];
    logic [2:0]          s_pin, s_low;
    logic [THR_W-1:0]    s_thr [3];
    logic [CNT_W-1:0]    s_inc [3];
    logic [SPEED_W-1:0]  speed_inc;
    logic [PERIOD_W-1:0] period_inc;
    logic [LED_W-1:0]    mod_inc;
    logic [WAIT_W-1:0]   wait_inc;
    logic                car_mid;
    logic                stop, clr, spd, led, lng;

    assign l_pin    = {i_item.hor_pin, i_item.ver_pin};
    assign l_thr[0] = i_cfg.limit_threshold;
    assign l_thr[1] = i_cfg.limit_threshold;
    assign s_pin    = {i_item.ground_pin, i_item.radar_pin, i_item.air_pin};
    assign s_thr[0] = i_cfg.air_threshold;
    assign s_thr[1] = i_cfg.radar_threshold;
    assign s_thr[2] = i_cfg.ground_threshold;

    // count increments (saturating for the pin counts) and the two-sample low test
    always_comb begin
        for (int i = 0; i < 2; i++) begin
            l_inc[i] = (r_limit_cnt[i] == CNT_MAX) ? r_limit_cnt[i] : r_limit_cnt[i] + 1'b1;
            l_low[i] = !l_pin[i] && !r_limit_prev[i];
        end
        for (int i = 0; i < 3; i++) begin
            s_inc[i] = (r_sens_cnt[i] == CNT_MAX) ? r_sens_cnt[i] : r_sens_cnt[i] + 1'b1;
            s_low[i] = !s_pin[i] && !r_sens_prev[i];
        end
        speed_inc  = r_speed_cnt + 1'b1;
        period_inc = r_period_cnt + 1'b1;
        wait_inc   = r_wait_cnt + 1'b1;
        // running remainder of the period count by the led period
        if (r_period_cnt == '1) begin
            mod_inc = '0;
        end else if (({1'b0, r_led_mod} + 1'b1) == {1'b0, i_cfg.led_period}) begin
            mod_inc = '0;
        end else begin
            mod_inc = r_led_mod + 1'b1;
        end
    end

    always_comb begin
        n_limit_prev = r_limit_prev;
        n_limit_flag = r_limit_flag;
        n_dir        = r_dir;
        n_speed_cnt  = r_speed_cnt;
        n_period_cnt = r_period_cnt;
        n_led_mod    = r_led_mod;
        n_sens_prev  = r_sens_prev;
        n_sens_lat   = r_sens_lat;
        n_car        = r_car;
        n_wait_cnt   = r_wait_cnt;
        car_mid      = r_car;
        l_hit        = '0;
        stop         = 1'b0;
        clr          = 1'b0;
        spd          = 1'b0;
        led          = 1'b0;
        lng          = 1'b0;
        for (int i = 0; i < 2; i++) begin
            n_limit_cnt[i] = r_limit_cnt[i];
        end
        for (int i = 0; i < 3; i++) begin
            n_sens_cnt[i] = r_sens_cnt[i];
        end

        if (i_mod.load) begin
            n_led_mod = i_mod.value;
        end

        if (i_step && !i_item.mode) begin
            // fast tick: limit pins
            for (int i = 0; i < 2; i++) begin
                if (l_low[i]) begin
                    if (l_inc[i] > {1'b0, l_thr[i]}) begin
                        n_limit_flag[i] = 1'b1;
                        n_limit_cnt[i]  = '0;
                        l_hit[i]        = 1'b1;
                    end else begin
                        n_limit_cnt[i] = l_inc[i];
                    end
                end else begin
                    n_limit_flag[i] = 1'b0;
                    n_limit_cnt[i]  = '0;
                end
                n_limit_prev[i] = l_pin[i];
            end
            // vertical first, so both may reverse in one tick
            if (l_hit[0] && !r_dir) begin
                n_dir = 1'b1;
                stop  = 1'b1;
            end
            if (l_hit[1] && n_dir) begin
                n_dir = 1'b0;
                stop  = 1'b1;
                clr   = 1'b1;
            end
        end else if (i_step) begin
            // slow tick: dividers and sensors
            car_mid = r_car || i_item.car_announce;

            if (speed_inc > i_cfg.speed_divide) begin
                spd         = 1'b1;
                n_speed_cnt = '0;
            end else begin
                n_speed_cnt = speed_inc;
            end

            led = (i_cfg.led_period != '0) && (mod_inc == '0);
            if (period_inc > i_cfg.long_period) begin
                lng          = 1'b1;
                n_period_cnt = '0;
                n_led_mod    = '0;
            end else begin
                n_period_cnt = period_inc;
                n_led_mod    = mod_inc;
            end

            for (int i = 0; i < 3; i++) begin
                if (s_low[i]) begin
                    if (!r_sens_lat[i]) begin
                        if (s_inc[i] > {1'b0, s_thr[i]}) begin
                            n_sens_lat[i] = 1'b1;
                            n_sens_cnt[i] = '0;
                        end else begin
                            n_sens_cnt[i] = s_inc[i];
                        end
                    end
                end else begin
                    n_sens_lat[i] = 1'b0;
                    n_sens_cnt[i] = '0;
                end
                n_sens_prev[i] = s_pin[i];
            end

            // ground release drops a waiting car
            n_car = car_mid && !(!s_low[2] && r_sens_lat[2]);

            if (n_car) begin
                if (wait_inc > i_cfg.car_timeout) begin
                    n_wait_cnt = '0;
                    n_car      = 1'b0;
                end else begin
                    n_wait_cnt = wait_inc;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_limit_prev <= '0;
            r_limit_flag <= '0;
            r_dir        <= 1'b0;
            r_speed_cnt  <= '0;
            r_period_cnt <= '0;
            r_led_mod    <= '0;
            r_sens_prev  <= '0;
            r_sens_lat   <= '0;
            r_car        <= 1'b0;
            r_wait_cnt   <= '0;
            for (int i = 0; i < 2; i++) begin
                r_limit_cnt[i] <= '0;
            end
            for (int i = 0; i < 3; i++) begin
                r_sens_cnt[i] <= '0;
            end
        end else begin
            r_limit_prev <= n_limit_prev;
            r_limit_flag <= n_limit_flag;
            r_dir        <= n_dir;
            r_speed_cnt  <= n_speed_cnt;
            r_period_cnt <= n_period_cnt;
            r_led_mod    <= n_led_mod;
            r_sens_prev  <= n_sens_prev;
            r_sens_lat   <= n_sens_lat;
            r_car        <= n_car;
            r_wait_cnt   <= n_wait_cnt;
            for (int i = 0; i < 2; i++) begin
                r_limit_cnt[i] <= n_limit_cnt[i];
            end
            for (int i = 0; i < 3; i++) begin
                r_sens_cnt[i] <= n_sens_cnt[i];
            end
        end
    end

    assign o_period_count = r_period_cnt;

    assign o_result.ver_reached       = n_limit_flag[0];
    assign o_result.hor_reached       = n_limit_flag[1];
    assign o_result.move_down         = n_dir;
    assign o_result.stop_pulse        = stop;
    assign o_result.clear_speed_pulse = clr;
    assign o_result.speed_tick        = spd;
    assign o_result.led_tick          = led;
    assign o_result.long_tick         = lng;
    assign o_result.air_detect        = n_sens_lat[0];
    assign o_result.radar_detect      = n_sens_lat[1];
    assign o_result.ground_detect     = n_sens_lat[2];
    assign o_result.car_waiting       = n_car;

endmodule

### design/gate_sensor_qualifier_top.sv
// top level of the gate sensor qualifier
// usage:
//   each input request is one tick: mode 0 is a fast tick that debounces the
//   vertical and horizontal limit pins, mode 1 a slow tick that steps the
//   speed, led and long dividers and qualifies the air, radar and ground pins
//   input channel: i_in_valid / o_in_stall / i_in_data, taken when valid and
//   not stall; output channel: o_out_valid / i_out_stall / o_out_data
//   a taken request is held in the input register, its result in the result
//   register, which drives o_out_valid; throughput: one request per cycle,
//   sustained, while the output is taken and no remainder rebuild runs; an
//   output stall holds the result register; the input register is held behind
//   it and o_in_stall rises while both are full; config port: i_cfg_valid /
//   o_cfg_ready, always ready, written while idle (by the user; the block does
//   not enforce it); a write of led_period starts a bit-serial remainder of
//   the period count, one dividend bit per cycle; input stays stalled until done
//   reset (i_rst_n low, synchronous) clears all counters and flags, sets the
//   direction to up and loads the default register values
`timescale 1ns / 1ps
`include "gate_sensor_qualifier_top_defines.svh"
module gate_sensor_qualifier_top import gsq_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  t_in_item              i_in_data,
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output t_out_item             o_out_data,
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    t_cfg                cfg;
    logic                led_wr;
    logic                rem_busy;
    t_mod_load           mod_load;
    logic [PERIOD_W-1:0] period_count;
    t_out_item           result;

    // pipeline control
    logic      r_in_vld;
    t_in_item  r_in;
    logic      r_out_vld;
    t_out_item r_out;
    logic      in_take;
    logic      adv;

    // config writes are never refused
    assign o_cfg_ready = 1'b1;

    gsq_cfg_regs u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (i_cfg_valid && o_cfg_ready),
        .i_index (i_cfg_index),
        .i_data  (i_cfg_data),
        .o_cfg   (cfg),
        .o_led_wr(led_wr)
    );

    // rebuilds the running led remainder after a new led period
    gsq_rem_unit u_rem (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (led_wr),
        .i_dividend(period_count),
        .i_divisor (i_cfg_data[LED_W-1:0]),
        .o_busy    (rem_busy),
        .o_result  (mod_load)
    );

    // the registered request meets the state here; its result is registered below
    gsq_qualify u_qual (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_step        (adv),
        .i_item        (r_in),
        .i_cfg         (cfg),
        .i_mod         (mod_load),
        .o_period_count(period_count),
        .o_result      (result)
    );

    // the input register moves on when the result register is free or emptying
    assign adv        = r_in_vld && (!r_out_vld || !i_out_stall);
    assign o_in_stall = rem_busy || (r_in_vld && !adv);
    assign in_take    = i_in_valid && !o_in_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld  <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            if (in_take) begin
                r_in_vld <= 1'b1;
            end else if (adv) begin
                r_in_vld <= 1'b0;
            end
            if (adv) begin
                r_out_vld <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_in <= i_in_data;
        end
        if (adv) begin
            r_out <= result;
        end
    end

    assign o_out_valid = r_out_vld;
    assign o_out_data  = r_out;

    // a taken request always lands in the input register
    `GSQ_ASSERT_NEXT(a_take_lands, in_take, r_in_vld, "accepted request not registered")
    // a request held behind a stalled result keeps its payload
    `GSQ_ASSERT_NEXT(a_hold_in, r_in_vld && !adv, r_in_vld && $stable(r_in), "held request lost")
    // clear speed only ever comes with a stop
    `GSQ_ASSERT_NOW(a_clr_stop, o_out_valid && o_out_data.clear_speed_pulse,
        o_out_data.stop_pulse, "clear speed pulse without stop")
    // no request is taken while the remainder unit is rebuilding
    `GSQ_ASSERT_NOW(a_no_take_busy, rem_busy, !in_take, "request taken during remainder rebuild")

endmodule

### tb/gsq_result_checker.sv
// result checker for the gate sensor qualifier: predicts every tick and compares results
`timescale 1ns / 1ps
module gsq_result_checker import gsq_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    input  logic                  i_in_stall,
    input  t_in_item              i_in_data,
    input  logic                  i_out_valid,
    input  logic                  i_out_stall,
    input  t_out_item             i_out_data,
    input  logic                  i_cfg_valid,
    input  logic                  i_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    output int                    o_fail_count,
    output int                    o_pending,
    output int                    o_checked,
    output int                    o_reversals
);

    localparam int VER_CH    = 0;
    localparam int HOR_CH    = 1;
    localparam int AIR_CH    = 0;
    localparam int RADAR_CH  = 1;
    localparam int GROUND_CH = 2;
    localparam int SHOW_MAX  = 10;

    t_out_item expected_flags [$];
    t_cfg      regs;

    logic                lim_prev [2];
    logic                lim_flag [2];
    logic [CNT_W-1:0]    lim_cnt [2];
    logic                move_down;
    logic [SPEED_W-1:0]  speed_cnt;
    logic [PERIOD_W-1:0] period_cnt;
    logic                sns_prev [3];
    logic                sns_latched [3];
    logic [CNT_W-1:0]    sns_cnt [3];
    logic                car_flag;
    logic [WAIT_W-1:0]   wait_cnt;

    int fail_count = 0;
    int pending    = 0;
    int checked    = 0;
    int reversals  = 0;

    assign o_fail_count = fail_count;
    assign o_pending    = pending;
    assign o_checked    = checked;
    assign o_reversals  = reversals;

    function automatic void reset_model();
        regs.limit_threshold  = RST_LIMIT_THR;
        regs.air_threshold    = RST_AIR_THR;
        regs.radar_threshold  = RST_RADAR_THR;
        regs.ground_threshold = RST_GROUND_THR;
        regs.speed_divide     = RST_SPEED_DIV;
        regs.led_period       = RST_LED_PERIOD;
        regs.long_period      = RST_LONG_PER;
        regs.car_timeout      = RST_CAR_TMO;
        for (int i = 0; i < 2; i++) begin
            lim_prev[i] = 1'b0;
            lim_flag[i] = 1'b0;
            lim_cnt[i]  = '0;
        end
        for (int i = 0; i < 3; i++) begin
            sns_prev[i]    = 1'b0;
            sns_latched[i] = 1'b0;
            sns_cnt[i]     = '0;
        end
        move_down  = 1'b0;
        speed_cnt  = '0;
        period_cnt = '0;
        car_flag   = 1'b0;
        wait_cnt   = '0;
    endfunction

    // true when the limit pin has just qualified
    function automatic logic debounce_limit(int ch, logic pin);
        logic hit;
        hit = 1'b0;
        if (!pin && !lim_prev[ch]) begin
            if (lim_cnt[ch] != '1) lim_cnt[ch] = lim_cnt[ch] + 1'b1;
            if (lim_cnt[ch] > {1'b0, regs.limit_threshold}) begin
                lim_flag[ch] = 1'b1;
                lim_cnt[ch]  = '0;
                hit          = 1'b1;
            end
        end else begin
            lim_flag[ch] = 1'b0;
            lim_cnt[ch]  = '0;
        end
        lim_prev[ch] = pin;
        return hit;
    endfunction

    function automatic void qualify_sensor(int ch, logic pin, logic [THR_W-1:0] thr);
        if (!pin && !sns_prev[ch]) begin
            if (!sns_latched[ch]) begin
                if (sns_cnt[ch] != '1) sns_cnt[ch] = sns_cnt[ch] + 1'b1;
                if (sns_cnt[ch] > {1'b0, thr}) begin
                    sns_latched[ch] = 1'b1;
                    sns_cnt[ch]     = '0;
                end
            end
        end else begin
            // ground release drops a waiting car
            if (ch == GROUND_CH && sns_latched[ch] && car_flag) car_flag = 1'b0;
            sns_latched[ch] = 1'b0;
            sns_cnt[ch]     = '0;
        end
        sns_prev[ch] = pin;
    endfunction

    function automatic t_out_item qualify_tick(t_in_item tick);
        t_out_item res;
        res = '0;
        if (!tick.mode) begin
            if (debounce_limit(VER_CH, tick.ver_pin) && !move_down) begin
                move_down      = 1'b1;
                res.stop_pulse = 1'b1;
            end
            if (debounce_limit(HOR_CH, tick.hor_pin) && move_down) begin
                move_down             = 1'b0;
                res.stop_pulse        = 1'b1;
                res.clear_speed_pulse = 1'b1;
            end
        end else begin
            if (tick.car_announce) car_flag = 1'b1;
            speed_cnt = speed_cnt + 1'b1;
            if (speed_cnt > regs.speed_divide) begin
                res.speed_tick = 1'b1;
                speed_cnt      = '0;
            end
            period_cnt = period_cnt + 1'b1;
            if (regs.led_period != '0
                && (period_cnt % {{(PERIOD_W-LED_W){1'b0}}, regs.led_period}) == '0)
                res.led_tick = 1'b1;
            if (period_cnt > regs.long_period) begin
                res.long_tick = 1'b1;
                period_cnt    = '0;
            end
            qualify_sensor(AIR_CH, tick.air_pin, regs.air_threshold);
            qualify_sensor(RADAR_CH, tick.radar_pin, regs.radar_threshold);
            qualify_sensor(GROUND_CH, tick.ground_pin, regs.ground_threshold);
            if (car_flag) begin
                wait_cnt = wait_cnt + 1'b1;
                if (wait_cnt > regs.car_timeout) begin
                    wait_cnt = '0;
                    car_flag = 1'b0;
                end
            end
        end
        res.ver_reached   = lim_flag[VER_CH];
        res.hor_reached   = lim_flag[HOR_CH];
        res.move_down     = move_down;
        res.air_detect    = sns_latched[AIR_CH];
        res.radar_detect  = sns_latched[RADAR_CH];
        res.ground_detect = sns_latched[GROUND_CH];
        res.car_waiting   = car_flag;
        return res;
    endfunction

    function automatic string show(t_out_item f);
        return $sformatf({"ver=%b hor=%b down=%b stop=%b clr=%b spd=%b led=%b long=%b",
                          " air=%b radar=%b gnd=%b car=%b"},
                         f.ver_reached, f.hor_reached, f.move_down, f.stop_pulse,
                         f.clear_speed_pulse, f.speed_tick, f.led_tick, f.long_tick,
                         f.air_detect, f.radar_detect, f.ground_detect, f.car_waiting);
    endfunction

    always @(posedge i_clk) begin : watch
        t_out_item want;
        if (!i_rst_n) begin
            reset_model();
            expected_flags.delete();
        end else begin
            // a result always belongs to an earlier request, so check before predicting
            if (i_out_valid && !i_out_stall) begin
                if (expected_flags.size() == 0) begin
                    fail_count++;
                    if (fail_count <= SHOW_MAX)
                        $display("unexpected result at %0t: %s", $realtime, show(i_out_data));
                end else begin
                    want = expected_flags.pop_front();
                    if (i_out_data !== want) begin
                        fail_count++;
                        if (fail_count <= SHOW_MAX)
                            $display("mismatch on result %0d\n  expected %s\n  actual   %s",
                                     checked, show(want), show(i_out_data));
                    end
                    checked++;
                end
            end
            if (i_cfg_valid && i_cfg_ready) begin
                case (t_cfg_idx'(i_cfg_index))
                    CFG_LIMIT_THR:  regs.limit_threshold  = i_cfg_data[THR_W-1:0];
                    CFG_AIR_THR:    regs.air_threshold    = i_cfg_data[THR_W-1:0];
                    CFG_RADAR_THR:  regs.radar_threshold  = i_cfg_data[THR_W-1:0];
                    CFG_GROUND_THR: regs.ground_threshold = i_cfg_data[THR_W-1:0];
                    CFG_SPEED_DIV:  regs.speed_divide     = i_cfg_data[SPEED_W-1:0];
                    CFG_LED_PERIOD: regs.led_period       = i_cfg_data[LED_W-1:0];
                    CFG_LONG_PER:   regs.long_period      = i_cfg_data[PERIOD_W-1:0];
                    CFG_CAR_TMO:    regs.car_timeout      = i_cfg_data[WAIT_W-1:0];
                    default: ;
                endcase
            end
            if (i_in_valid && !i_in_stall) begin
                want = qualify_tick(i_in_data);
                if (want.stop_pulse) reversals++;
                expected_flags.push_back(want);
            end
        end
        pending = expected_flags.size();
    end

endmodule

### tb/testbench.sv
// top of the gate sensor qualifier testbench: stimulus, output stalls and verdict
`timescale 1ns / 1ps
module testbench;
    import gsq_pkg::*;

    localparam int LONG_HOLD     = 48;        // cycles of the one long output hold
    localparam int TIME_LIMIT_NS = 1_000_000; // far beyond the slowest legal run
    localparam int SETTLE        = 4;         // covers the two pipeline stages and spare

    // pin slots used to shape the random pin levels
    localparam int PIN_VER    = 0;
    localparam int PIN_HOR    = 1;
    localparam int PIN_AIR    = 2;
    localparam int PIN_RADAR  = 3;
    localparam int PIN_GROUND = 4;

    logic                  clk       = 1'b0;
    logic                  rst_n     = 1'b0;
    logic                  in_valid  = 1'b0;
    t_in_item              in_data   = '0;
    logic                  out_stall = 1'b0;
    logic                  cfg_valid = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data  = '0;
    logic                  in_stall;
    logic                  out_valid;
    t_out_item             out_data;
    logic                  cfg_ready;

    int fail_count;
    int pending;
    int checked;
    int reversals;

    // calm switches all idling off for the closing stretch
    bit calm     = 1'b0;
    bit hold_req = 1'b0;

    // pin shaping: each pin sits at a level for a run of ticks of its own kind
    logic [THR_W-1:0] pin_thr [5];
    logic             pin_lvl [5];
    int               run_left [5];
    int               fast_ticks = 0;
    int               slow_ticks = 0;

    always begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    gate_sensor_qualifier_top uut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_data  (out_data),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (cfg_ready),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    gsq_result_checker u_checker (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_in_valid   (in_valid),
        .i_in_stall   (in_stall),
        .i_in_data    (in_data),
        .i_out_valid  (out_valid),
        .i_out_stall  (out_stall),
        .i_out_data   (out_data),
        .i_cfg_valid  (cfg_valid),
        .i_cfg_ready  (cfg_ready),
        .i_cfg_index  (cfg_index),
        .i_cfg_data   (cfg_data),
        .o_fail_count (fail_count),
        .o_pending    (pending),
        .o_checked    (checked),
        .o_reversals  (reversals)
    );

    function automatic t_in_item make_tick(logic slow, logic ver, logic hor, logic air,
                                           logic radar, logic gnd, logic ann);
        t_in_item tick;
        tick.mode         = slow;
        tick.ver_pin      = ver;
        tick.hor_pin      = hor;
        tick.air_pin      = air;
        tick.radar_pin    = radar;
        tick.ground_pin   = gnd;
        tick.car_announce = ann;
        return tick;
    endfunction

    // next level of a pin: low runs are often long enough to qualify, high runs short
    function automatic logic next_level(int p);
        int thr;
        thr = int'(pin_thr[p]);
        if (run_left[p] == 0) begin
            if (pin_lvl[p]) begin
                pin_lvl[p]  = 1'b0;
                run_left[p] = $urandom_range(0, 1) ? $urandom_range(thr + 2, thr + 4)
                                                   : $urandom_range(1, thr + 4);
            end else begin
                pin_lvl[p]  = 1'b1;
                run_left[p] = $urandom_range(1, 3);
            end
        end
        run_left[p]--;
        return pin_lvl[p];
    endfunction

    function automatic t_in_item random_tick();
        logic [6:0] noise;
        t_in_item   tick;
        noise = 7'($urandom);
        tick  = noise;
        // one tick in ten is plain noise that breaks the runs
        if ($urandom_range(0, 9) == 0) return tick;
        tick.mode = 1'($urandom_range(0, 1));
        if (!tick.mode) begin
            tick.ver_pin = next_level(PIN_VER);
            tick.hor_pin = next_level(PIN_HOR);
        end else begin
            tick.air_pin      = next_level(PIN_AIR);
            tick.radar_pin    = next_level(PIN_RADAR);
            tick.ground_pin   = next_level(PIN_GROUND);
            tick.car_announce = ($urandom_range(0, 7) == 0);
        end
        return tick;
    endfunction

    // offer one request and hold it until taken
    task automatic send_tick(t_in_item tick);
        @(negedge clk);
        in_valid <= 1'b1;
        in_data  <= tick;
        do @(posedge clk); while (in_stall);
        if (tick.mode) slow_ticks++;
        else fast_ticks++;
    endtask

    task automatic pause_input(int n);
        @(negedge clk);
        in_valid <= 1'b0;
        repeat (n) @(posedge clk);
    endtask

    // let every expected result come back before going on
    task automatic wait_for_results();
        @(negedge clk);
        in_valid <= 1'b0;
        while (pending != 0) @(negedge clk);
        repeat (SETTLE) @(negedge clk);
    endtask

    task automatic write_reg(t_cfg_idx idx, logic [CFG_DATA_W-1:0] value);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        do @(posedge clk); while (!cfg_ready);
        @(negedge clk);
        cfg_valid <= 1'b0;
        // the pin shaping follows the thresholds
        case (idx)
            CFG_LIMIT_THR: begin
                pin_thr[PIN_VER] = value[THR_W-1:0];
                pin_thr[PIN_HOR] = value[THR_W-1:0];
            end
            CFG_AIR_THR:    pin_thr[PIN_AIR]    = value[THR_W-1:0];
            CFG_RADAR_THR:  pin_thr[PIN_RADAR]  = value[THR_W-1:0];
            CFG_GROUND_THR: pin_thr[PIN_GROUND] = value[THR_W-1:0];
            default: ;
        endcase
    endtask

    task automatic apply_setting(int lim, int air, int radar, int gnd, int spd,
                                 int led, int lng, int tmo);
        write_reg(CFG_LIMIT_THR, CFG_DATA_W'(lim));
        write_reg(CFG_AIR_THR, CFG_DATA_W'(air));
        write_reg(CFG_RADAR_THR, CFG_DATA_W'(radar));
        write_reg(CFG_GROUND_THR, CFG_DATA_W'(gnd));
        write_reg(CFG_SPEED_DIV, CFG_DATA_W'(spd));
        write_reg(CFG_LED_PERIOD, CFG_DATA_W'(led));
        write_reg(CFG_LONG_PER, CFG_DATA_W'(lng));
        write_reg(CFG_CAR_TMO, CFG_DATA_W'(tmo));
    endtask

    task automatic apply_small_setting();
        apply_setting($urandom_range(0, 12), $urandom_range(0, 8), $urandom_range(0, 8),
                      $urandom_range(0, 8), $urandom_range(0, 6), $urandom_range(1, 20),
                      $urandom_range(1, 60), $urandom_range(0, 80));
    endtask

    task automatic random_run(int n);
        bit quiet;
        quiet = 1'b0;
        for (int k = 0; k < n; k++) begin
            // now and then a stretch with no input gaps at all
            if (k % 40 == 0) quiet = ($urandom_range(0, 3) == 0);
            if (!calm && !quiet && $urandom_range(0, 4) == 0)
                pause_input($urandom_range(1, 14));
            send_tick(random_tick());
        end
    endtask

    // output side: random stall bursts, one long hold on request, none when calm
    initial begin : out_side
        bit held;
        held = 1'b0;
        forever begin
            @(negedge clk);
            if (calm) begin
                out_stall <= 1'b0;
            end else if (hold_req && !held) begin
                held = 1'b1;
                out_stall <= 1'b1;
                for (int n = 0; n < LONG_HOLD; n++) @(negedge clk);
                out_stall <= 1'b0;
            end else if ($urandom_range(0, 3) == 0) begin
                out_stall <= 1'b1;
                repeat ($urandom_range(1, 14) - 1) @(negedge clk);
            end else begin
                out_stall <= 1'b0;
                repeat ($urandom_range(0, 40)) @(negedge clk);
            end
        end
    end

    initial begin : run_limit
        #(TIME_LIMIT_NS);
        $display("run timed out with %0d results outstanding", pending);
        $display("** gate_sensor_qualifier_top: FAILED **");
        $finish;
    end

    initial begin : stimulus
        pin_thr[PIN_VER]    = RST_LIMIT_THR;
        pin_thr[PIN_HOR]    = RST_LIMIT_THR;
        pin_thr[PIN_AIR]    = RST_AIR_THR;
        pin_thr[PIN_RADAR]  = RST_RADAR_THR;
        pin_thr[PIN_GROUND] = RST_GROUND_THR;
        for (int p = 0; p < 5; p++) begin
            pin_lvl[p]  = 1'b1;
            run_left[p] = 0;
        end

        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // reset values of all registers
        random_run(200);
        wait_for_results();

        // directed ticks with zero thresholds, widest speed divide and both periods at one
        apply_setting(0, 0, 0, 0, 255, 1, 1, 0);
        send_tick(make_tick(1'b0, 1'b1, 1'b1, 1'b1, 1'b1, 1'b1, 1'b1)); // announce on fast
        send_tick(make_tick(1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b1));
        send_tick(make_tick(1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0)); // both limits
        send_tick(make_tick(1'b0, 1'b0, 1'b1, 1'b1, 1'b1, 1'b1, 1'b0));
        send_tick(make_tick(1'b0, 1'b0, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0)); // vertical again
        send_tick(make_tick(1'b0, 1'b1, 1'b0, 1'b1, 1'b1, 1'b1, 1'b1));
        send_tick(make_tick(1'b0, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0)); // horizontal
        send_tick(make_tick(1'b1, 1'b1, 1'b1, 1'b1, 1'b1, 1'b1, 1'b1)); // car, instant timeout
        send_tick(make_tick(1'b1, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0));
        send_tick(make_tick(1'b1, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0)); // sensors latch
        send_tick(make_tick(1'b1, 1'b1, 1'b1, 1'b0, 1'b0, 1'b0, 1'b1));
        send_tick(make_tick(1'b1, 1'b0, 1'b0, 1'b0, 1'b0, 1'b1, 1'b0)); // ground release
        send_tick(make_tick(1'b1, 1'b1, 1'b1, 1'b1, 1'b1, 1'b1, 1'b0));
        send_tick(make_tick(1'b0, 1'b1, 1'b1, 1'b1, 1'b1, 1'b1, 1'b0));
        send_tick(make_tick(1'b1, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b1));
        wait_for_results();

        // thresholds and led period at the top of their ranges, speed divide at zero, long periods near the top
        apply_setting(0, 0, 0, 0, 255, 1, 1, 0);
        apply_setting(255, 255, 255, 255, 0, 4095, 65534, 1048574);
        random_run(500);
        wait_for_results();

        // the output side holds off long enough to back the block up
        apply_setting(3, 2, 4, 1, 2, 7, 30, 41);
        hold_req = 1'b1;
        random_run(200);
        wait_for_results();

        // input side pauses mid-run until nothing is outstanding
        apply_setting(1, 5, 0, 3, 1, 3, 10, 25);
        random_run(100);
        wait_for_results();
        random_run(100);
        wait_for_results();

        apply_small_setting();
        random_run(200);
        wait_for_results();

        // closing stretch at full rate on both sides
        calm = 1'b1;
        apply_small_setting();
        random_run(200);
        wait_for_results();
        repeat (2 * SETTLE) @(negedge clk);

        $display("drove %0d ticks (%0d fast, %0d slow) over eight register settings",
                 fast_ticks + slow_ticks, fast_ticks, slow_ticks);
        $display("checked %0d results, %0d with a gate reversal, %0d mismatches",
                 checked, reversals, fail_count);
        if (fail_count == 0 && pending == 0) begin
            $display("** gate_sensor_qualifier_top: PASSED **");
        end else begin
            $display("** gate_sensor_qualifier_top: FAILED **");
        end
        $finish;
    end

endmodule

### gate_sensor_qualifier_top.f
+incdir+design
design/gsq_pkg.sv
design/gsq_cfg_regs.sv
design/gsq_rem_unit.sv
design/gsq_qualify.sv
design/gate_sensor_qualifier_top.sv
tb/gsq_result_checker.sv
tb/testbench.sv
